// File: rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types and constants for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } core_state_t;

    typedef logic [31:0] word_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t w;
        begin
            w = 32'h0;
            unique case (idx)
                3'd0: w = 32'h6a09e667;
                3'd1: w = 32'hbb67ae85;
                3'd2: w = 32'h3c6ef372;
                3'd3: w = 32'ha54ff53a;
                3'd4: w = 32'h510e527f;
                3'd5: w = 32'h9b05688c;
                3'd6: w = 32'h1f83d9ab;
                3'd7: w = 32'h5be0cd19;
                default: w = 32'h0;
            endcase
            return w;
        end
    endfunction

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

// File: rtl/sha256_byte_stream_hasher.sv
// Flow: data beats are written into the block buffer; each full block is then
// loaded into the word shifter, run through the single round unit and added.
// Finish pads one byte per cycle while no block is hashed, then eight digest beats follow.
// New bytes are not taken while a block is being hashed; the input queue
// holds the beats that arrive meanwhile.
// Reset: asynchronous, active low; hash returns to the initial values.
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Top level: input queue feeding the hashing core.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero pad
    output logic        m_tlast    // last_word
);
    import sha256_pkg::*;

    beat_t in_beat, q_beat;
    logic  q_valid, q_ready;
    logic [31:0] dw;
    logic [2:0]  wi;

    assign in_beat.kind      = s_tuser;
    assign in_beat.data_byte = s_tdata;

    sha256_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_beat   (in_beat),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_beat  (q_beat)
    );

    sha256_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_beat     (q_beat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .digest_word (dw),
        .word_index  (wi),
        .last_word   (m_tlast)
    );

    assign m_tdata = {5'b0, wi, dw};
endmodule

// File: rtl/sha256_fifo.sv
// ----------------------------------------------------------------------------
// SHA-256 beat queue
// Short queue between the input side and the hashing core.
// ----------------------------------------------------------------------------
module sha256_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sha256_pkg::beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output sha256_pkg::beat_t  out_beat
);
    import sha256_pkg::*;

    beat_t      mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 3'd4);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_beat  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {2'b0, push} - {2'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

// File: rtl/sha256_core.sv
// ----------------------------------------------------------------------------
// SHA-256 core
// Buffers message bytes, pads on finish, runs 64 rounds per block and
// emits the digest words.
// ----------------------------------------------------------------------------
module sha256_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sha256_pkg::beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               last_word
);
    import sha256_pkg::*;

    core_state_t st_reg, st_next;

    logic [7:0]  buf_mem [64];
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    logic [5:0]  fill_reg;
    logic [60:0] bytes_reg;
    logic [5:0]  rnd_reg;
    logic [5:0]  ld_reg;
    logic [2:0]  emit_reg;
    logic        pad_reg;
    logic        fin_reg;
    logic        len_reg;
    logic [63:0] bits_reg;
    logic [7:0]  rd_data_reg;

    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic        wr_en;
    logic [7:0]  pad_data;
    word_t       s0, s1, t1, t2, bs0, bs1, ch, mj, wnew, wcur;
    logic        take;

    assign take     = in_valid && in_ready;
    assign in_ready = (st_reg == ST_IDLE) && !pad_reg;

    // The length bytes fill the tail of the block that holds the pad byte if it has
    // room for them, else the tail of the next block; otherwise the tail is zero.
    always_comb
    begin
        if (fill_reg >= 6'd56 && len_reg)
        begin
            pad_data = bits_reg[8'd63 - {2'b0, fill_reg[2:0], 3'b0} -: 8];
        end
        else
        begin
            pad_data = 8'h00;
        end
        if (!fin_reg)
        begin
            pad_data = PAD_BYTE;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg;
        wr_data = in_beat.data_byte;
        if (st_reg == ST_IDLE && pad_reg)
        begin
            wr_en   = 1'b1;
            wr_data = pad_data;
        end
        else if (take && in_beat.kind == KIND_DATA)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        wcur = w_reg[0];
        s0   = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
               ^ (w_reg[1] >> 3);
        s1   = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
               ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        bs1  = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
               ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + bs1 + ch + ROUND_K[rnd_reg] + wcur;
        bs0  = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
               ^ {v_reg[0][21:0], v_reg[0][31:22]};
        mj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = bs0 + mj;
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (wr_en && fill_reg == 6'd63)
                begin
                    st_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (ld_reg == 6'd63)
                begin
                    st_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    st_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                st_next = ST_IDLE;
                if (pad_reg && len_reg)
                begin
                    st_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready && emit_reg == 3'd7)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid   = (st_reg == ST_EMIT);
        digest_word = h_reg[emit_reg];
        word_index  = emit_reg;
        last_word   = (emit_reg == 3'd7);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= buf_mem[ld_reg];
    end

    // The last byte enters the word shifter in the cycle after the final read,
    // so the first round cycle shifts that one more byte in.
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_LOAD)
        begin
            if (ld_reg != 6'd0)
            begin
                w_reg[15] <= {w_reg[15][23:0], rd_data_reg};
                if (ld_reg[1:0] == 2'd1)
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                end
            end
            if (ld_reg == 6'd63)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
        end
        else if (st_reg == ST_ROUND)
        begin
            for (int i = 0; i < 14; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[14] <= (rnd_reg == 6'd0) ? {w_reg[15][23:0], rd_data_reg} : w_reg[15];
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (st_reg == ST_IDLE && take && in_beat.kind == KIND_FINISH)
        begin
            bits_reg <= {bytes_reg, 3'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            fill_reg  <= 6'd0;
            bytes_reg <= 61'd0;
            rnd_reg   <= 6'd0;
            ld_reg    <= 6'd0;
            emit_reg  <= 3'd0;
            pad_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            len_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            st_reg <= st_next;
            if (wr_en)
            begin
                fill_reg <= fill_reg + 6'd1;
                if (pad_reg)
                begin
                    fin_reg <= 1'b1;
                    if ((!fin_reg && fill_reg < 6'd56) || fill_reg == 6'd0)
                    begin
                        len_reg <= 1'b1;
                    end
                end
            end
            if (take)
            begin
                if (in_beat.kind == KIND_DATA)
                begin
                    bytes_reg <= bytes_reg + 61'd1;
                end
                else
                begin
                    pad_reg <= 1'b1;
                    fin_reg <= 1'b0;
                end
            end
            if (st_reg == ST_LOAD)
            begin
                ld_reg <= ld_reg + 6'd1;
            end
            if (st_reg == ST_ROUND)
            begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (st_reg == ST_UPDATE)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (st_reg == ST_EMIT && out_ready)
            begin
                emit_reg <= emit_reg + 3'd1;
                if (emit_reg == 3'd7)
                begin
                    pad_reg   <= 1'b0;
                    fin_reg   <= 1'b0;
                    len_reg   <= 1'b0;
                    bytes_reg <= 61'd0;
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= init_hash(3'(i));
                    end
                end
            end
        end
    end
endmodule

// File: rtl/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Checks digest ordering, the last flag, pad bits and stalled beats on the result stream.
// ----------------------------------------------------------------------------
module sha256_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
        else $error("tlast does not match word index");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:35] == 5'd0))
        else $error("pad bits set");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid &&
        m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("digest words out of order");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled beat changed");
endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: test/sha256_byte_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Sends message bytes and finish beats, computes each digest with its own
// SHA-256 model, and checks every digest beat against the queued words.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_tb;

    import sha256_pkg::*;

    typedef struct {
        logic       kind;
        logic [7:0] data_byte;
        logic       known;
        word_t      digest0;
    } vector_t;

    typedef struct {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } digest_beat_t;

    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    word_t        hash_state [8];
    logic [7:0]   msg_block [64];
    int unsigned  fill_level;
    logic [60:0]  msg_length;
    digest_beat_t pending_words [$];
    int           error_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_cycles;
    longint       cycle_count;
    vector_t      vectors [$];

    sha256_byte_stream_hasher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    function automatic word_t rotr(word_t v, int r);
        return (v >> r) | (v << (32 - r));
    endfunction

    function automatic void compress_block();
        word_t w [64];
        word_t v [8];
        word_t t1;
        word_t t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        v = hash_state;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] += v[i];
        end
    endfunction

    function automatic void append_byte(logic [7:0] b);
        msg_block[fill_level] = b;
        fill_level = (fill_level + 1) % 64;
        if (fill_level == 0)
        begin
            compress_block();
        end
    endfunction

    function automatic void restart_message();
        hash_state = IV;
        fill_level = 0;
        msg_length = '0;
    endfunction

    function automatic void predict_digest(logic kind, logic [7:0] data_byte);
        logic [63:0]  bit_length;
        digest_beat_t d;
        if (kind == KIND_DATA)
        begin
            append_byte(data_byte);
            msg_length = msg_length + 1'b1;
            return;
        end
        bit_length = {msg_length, 3'b000};
        append_byte(PAD_BYTE);
        while (fill_level != 56)
        begin
            append_byte(8'h00);
        end
        for (int i = 0; i < 8; i++)
        begin
            append_byte(bit_length[63 - 8*i -: 8]);
        end
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = hash_state[i];
            d.word_index  = 3'(i);
            d.last_word   = (i == 7);
            pending_words = {pending_words, d};
        end
        restart_message();
    endfunction

    function automatic void add_vector(logic kind, logic [7:0] b, logic known = 0,
                                       word_t d0 = '0);
        vector_t v;
        v.kind = kind; v.data_byte = b; v.known = known; v.digest0 = d0;
        vectors = {vectors, v};
    endfunction

    task automatic send_beat(logic kind, logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_digest(kind, b);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
        begin
            send_beat(KIND_DATA, 8'($urandom));
        end
        send_beat(KIND_FINISH, 8'($urandom));
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        digest_beat_t exp;
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("FAIL");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected digest beat %h", m_tdata);
                error_count++;
            end
            else
            begin
                exp = pending_words.pop_front();
                if (m_tdata[31:0] !== exp.digest_word)
                begin
                    $error("digest_word expected %h actual %h", exp.digest_word, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[34:32] !== exp.word_index)
                begin
                    $error("word_index expected %0d actual %0d", exp.word_index,
                           m_tdata[34:32]);
                    error_count++;
                end
                if (m_tlast !== exp.last_word)
                begin
                    $error("last_word expected %b actual %b", exp.last_word, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_DATA;
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle_pct = 11;
        recv_idle_pct = 54;
        restart_message();

        // Empty message with data bits set, then "abc", then extreme bytes.
        add_vector(KIND_FINISH, 8'hff, 1, 32'he3b0c442);
        add_vector(KIND_DATA, 8'h61);
        add_vector(KIND_DATA, 8'h62);
        add_vector(KIND_DATA, 8'h63);
        add_vector(KIND_FINISH, 8'h00, 1, 32'hba7816bf);
        add_vector(KIND_DATA, 8'h00);
        add_vector(KIND_DATA, 8'hff);
        add_vector(KIND_DATA, 8'h55);
        add_vector(KIND_DATA, 8'haa);
        add_vector(KIND_FINISH, 8'h00);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
        begin
            send_beat(vectors[i].kind, vectors[i].data_byte);
            if (vectors[i].known)
            begin
                if (pending_words[pending_words.size() - 8].digest_word !== vectors[i].digest0)
                begin
                    $error("digest_word expected %h actual %h", vectors[i].digest0,
                           pending_words[pending_words.size() - 8].digest_word);
                    error_count++;
                end
            end
        end
        wait_drained();

        // Padding edge: a length that puts the length field in a second block.
        send_message(56);

        // Long receiver hold while the sender keeps offering messages.
        hold_cycles = 3000;
        send_message(2);
        send_message(0);
        send_message(5);
        send_message(1);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 11 : 0;
            for (int m = 0; m < 2; m++)
            begin
                send_message($urandom_range(0, 8));
            end
        end
        wait_drained();
        repeat (200) @(posedge clk);

        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
